// ===== sv/fprt_pkg.sv =====
// ----------------------------------------------------------------------------
// fprt_pkg - shared types and constants
// Table geometry, field widths, sequencer states and unit codes for the
// fragment pair reassembly table.
// ----------------------------------------------------------------------------
package fprt_pkg;

  localparam int TABLE_SLOTS = 8;
  localparam int HANDLE_BITS = 8;

  localparam int SEQ_W    = 16;
  localparam int HANDLE_W = 8;
  // stored handle bits: field width masked down to HANDLE_BITS
  localparam int STORE_W  = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
  localparam int SLOT_W   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

  localparam logic [SLOT_W-1:0] LAST_POS = SLOT_W'(TABLE_SLOTS - 1);

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_INSERT,
    ST_DONE
  } state_t;

  // recency list operations
  typedef enum logic [1:0] {
    ORD_HOLD,
    ORD_TO_OLDEST,
    ORD_TO_NEWEST
  } ord_op_t;

  typedef struct packed {
    ord_op_t           op;
    logic [SLOT_W-1:0] pos;
  } ord_ctl_t;

  // verdict of the compare unit for one visited slot
  typedef enum logic [1:0] {
    CMP_SKIP,
    CMP_NONE,
    CMP_STOP,
    CMP_MERGE
  } cmp_res_t;

endpackage

// ===== sv/fprt_cmp.sv =====
// ----------------------------------------------------------------------------
// fprt_cmp - slot compare unit
// Classifies one table slot against the fragment under search.
// ----------------------------------------------------------------------------
module fprt_cmp (
  input  logic                   slot_valid,
  input  logic [fprt_pkg::SEQ_W-1:0] slot_seq,
  input  logic                   slot_head,
  input  logic [fprt_pkg::SEQ_W-1:0] frag_seq,
  input  logic [fprt_pkg::SEQ_W-1:0] partner_seq,
  input  logic                   frag_head,
  output fprt_pkg::cmp_res_t     res
);
  import fprt_pkg::*;

  always_comb begin
    if (!slot_valid) begin
      res = CMP_SKIP;
    end else if (slot_seq == frag_seq) begin
      res = CMP_STOP;
    end else if (slot_seq == partner_seq) begin
      res = (slot_head != frag_head) ? CMP_MERGE : CMP_STOP;
    end else begin
      res = CMP_NONE;
    end
  end

endmodule

// ===== sv/fprt_order.sv =====
// ----------------------------------------------------------------------------
// fprt_order - recency list
// Slot indices from newest (position 0) to oldest; moves one entry to
// either end per cycle.
// ----------------------------------------------------------------------------
module fprt_order (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fprt_pkg::ord_ctl_t           ctl,
  output logic [fprt_pkg::SLOT_W-1:0]  rd_slot,
  output logic [fprt_pkg::SLOT_W-1:0]  oldest_slot
);
  import fprt_pkg::*;

  logic [SLOT_W-1:0] order_r [TABLE_SLOTS];

  assign rd_slot     = order_r[ctl.pos];
  assign oldest_slot = order_r[LAST_POS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        order_r[i] <= SLOT_W'(i);
      end
    end else begin
      case (ctl.op)
        ORD_TO_OLDEST: begin
          for (int i = 0; i < TABLE_SLOTS - 1; i++) begin
            if (i >= int'(ctl.pos)) begin
              order_r[i] <= order_r[i + 1];
            end
          end
          order_r[TABLE_SLOTS - 1] <= order_r[ctl.pos];
        end
        ORD_TO_NEWEST: begin
          // only ever used on the oldest entry: rotate toward the old end
          for (int i = 1; i < TABLE_SLOTS; i++) begin
            order_r[i] <= order_r[i - 1];
          end
          order_r[0] <= order_r[TABLE_SLOTS - 1];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== sv/fragment_pair_reassembly_table_top.sv =====
// ----------------------------------------------------------------------------
// fragment_pair_reassembly_table_top - fragment pair reassembly table
// Buffers half-packets in a recency-ordered table and pairs head and tail
// fragments by sequence number.
// ----------------------------------------------------------------------------
//
// Channel   Dir  tdata (low bit up)                          tuser
// in_*      in   frag_seqno[15:0], frag_handle[23:16]        frag_is_head
// out_*     out  first_handle[7:0], second_handle[15:8],     merged[0],
//                dropped_handle[23:16]                       dropped_valid[1]
//
// Sequence: one input transfer, then a search that visits up to TABLE_SLOTS
// slots newest to oldest (one slot per cycle through the shared compare
// unit), an insert step when no pair is formed, and a load of the output
// register.
// Reset (synchronous, rst_n low) empties the table and restores the
// recency list to ascending slot order.
// in_tready is high only while the sequencer is idle. A result held in the
// output register does not block the next input transfer; a finished result
// waits in the done state until the output register is free.
//
module fragment_pair_reassembly_table_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [fprt_pkg::IN_DATA_W-1:0]    in_tdata,  // seqno[15:0], handle[23:16]
  input  logic                              in_tuser,  // is_head
  // result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [fprt_pkg::OUT_DATA_W-1:0]   out_tdata, // first[7:0], second[15:8],
                                                       // dropped_handle[23:16]
  output logic [1:0]                        out_tuser  // merged[0], dropped_valid[1]
);
  import fprt_pkg::*;

  // sequencer
  state_t state_r, state_nxt;
  logic [SLOT_W-1:0] pos_r;

  // fragment under search
  logic [SEQ_W-1:0]   frag_seq_r;
  logic [SEQ_W-1:0]   partner_seq_r;
  logic               frag_head_r;
  logic [STORE_W-1:0] frag_handle_r;

  // table
  logic               slot_valid_r [TABLE_SLOTS];
  logic [SEQ_W-1:0]   slot_seq_r   [TABLE_SLOTS];
  logic               slot_head_r  [TABLE_SLOTS];
  logic [STORE_W-1:0] slot_buf_r   [TABLE_SLOTS];

  // result under construction, and the output register
  logic               res_merged_r;
  logic [HANDLE_W-1:0] res_first_r, res_second_r, res_drop_h_r;
  logic               res_drop_v_r;
  logic               out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [1:0]         out_user_r;

  // control
  ord_ctl_t          ord_ctl;
  logic [SLOT_W-1:0] rd_slot, oldest_slot;
  cmp_res_t          cmp_res;
  logic              out_free;
  logic              accept;

  fprt_order u_order (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ord_ctl),
    .rd_slot     (rd_slot),
    .oldest_slot (oldest_slot)
  );

  fprt_cmp u_cmp (
    .slot_valid  (slot_valid_r[rd_slot]),
    .slot_seq    (slot_seq_r[rd_slot]),
    .slot_head   (slot_head_r[rd_slot]),
    .frag_seq    (frag_seq_r),
    .partner_seq (partner_seq_r),
    .frag_head   (frag_head_r),
    .res         (cmp_res)
  );

  assign out_free = !out_valid_r || out_tready;
  assign accept   = in_tvalid && in_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (cmp_res == CMP_MERGE) begin
          state_nxt = ST_DONE;
        end else if (cmp_res == CMP_STOP || pos_r == LAST_POS) begin
          state_nxt = ST_INSERT;
        end
      end
      ST_INSERT: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready   = 1'b0;
    ord_ctl.op  = ORD_HOLD;
    ord_ctl.pos = pos_r;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_SEARCH: begin
        // a hit (merge or stop) sends the visited entry to the oldest end
        if (cmp_res == CMP_MERGE || cmp_res == CMP_STOP) ord_ctl.op = ORD_TO_OLDEST;
      end
      ST_INSERT: begin
        ord_ctl.op  = ORD_TO_NEWEST;
        ord_ctl.pos = LAST_POS;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // slot valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        slot_valid_r[i] <= 1'b0;
      end
    end else if (state_r == ST_SEARCH && cmp_res == CMP_MERGE) begin
      slot_valid_r[rd_slot] <= 1'b0;
    end else if (state_r == ST_INSERT) begin
      slot_valid_r[oldest_slot] <= 1'b1;
    end
  end

  // slot payload and working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      frag_seq_r    <= in_tdata[SEQ_W-1:0];
      frag_head_r   <= in_tuser;
      frag_handle_r <= in_tdata[SEQ_W +: STORE_W];
      partner_seq_r <= in_tuser ? SEQ_W'(in_tdata[SEQ_W-1:0] + 1'b1)
                                : SEQ_W'(in_tdata[SEQ_W-1:0] - 1'b1);
      pos_r         <= '0;
    end
    if (state_r == ST_SEARCH) begin
      pos_r <= SLOT_W'(pos_r + 1'b1);
      if (cmp_res == CMP_MERGE) begin
        res_merged_r <= 1'b1;
        res_first_r  <= frag_head_r ? HANDLE_W'(frag_handle_r)
                                    : HANDLE_W'(slot_buf_r[rd_slot]);
        res_second_r <= frag_head_r ? HANDLE_W'(slot_buf_r[rd_slot])
                                    : HANDLE_W'(frag_handle_r);
        res_drop_v_r <= 1'b0;
        res_drop_h_r <= '0;
      end
    end
    if (state_r == ST_INSERT) begin
      res_merged_r <= 1'b0;
      res_first_r  <= '0;
      res_second_r <= '0;
      res_drop_v_r <= slot_valid_r[oldest_slot];
      res_drop_h_r <= slot_valid_r[oldest_slot] ? HANDLE_W'(slot_buf_r[oldest_slot]) : '0;
      slot_seq_r[oldest_slot]  <= frag_seq_r;
      slot_head_r[oldest_slot] <= frag_head_r;
      slot_buf_r[oldest_slot]  <= frag_handle_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_data_r <= {res_drop_h_r, res_second_r, res_first_r};
      out_user_r <= {res_drop_v_r, res_merged_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== verif/fragment_pair_reassembly_table_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fragment_pair_reassembly_table_top_test - pairing table regression
// Streams fragments into the pairing table and checks each result against a
// local predictor of the recency-ordered table. The run starts with directed
// cases: wrap of the sequence number, merges in both orders, an equal number
// already buffered, a same-flag partner, and eviction from a full table.
// Random traffic follows. Most of it is opened and closed pairs with random
// content, and the rest is duplicates, same-flag partners and noise. Both
// channels idle at random.
// ----------------------------------------------------------------------------
module fragment_pair_reassembly_table_top_test;
  import fprt_pkg::*;

  localparam int                CLK_HALF    = 5;
  localparam int                RANDOM_FRAGS = 1800;
  localparam int                CYCLE_LIMIT = 1000000;
  // drain time after the last result: a full search plus margin
  localparam int                DRAIN_CYCLES = 4 * (TABLE_SLOTS + 3);
  localparam logic [HANDLE_W-1:0] HANDLE_MASK = HANDLE_W'((64'd1 << STORE_W) - 1);

  typedef struct packed {
    logic [SEQ_W-1:0]    seqno;
    logic                is_head;
    logic [HANDLE_W-1:0] handle;
  } frag_t;

  typedef struct packed {
    logic                merged;
    logic [HANDLE_W-1:0] first_handle;
    logic [HANDLE_W-1:0] second_handle;
    logic                dropped_valid;
    logic [HANDLE_W-1:0] dropped_handle;
  } pair_result_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // seqno[15:0], handle[23:16]
  logic                  in_tuser   = 1'b0; // is_head
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // first[7:0], second[15:8], dropped[23:16]
  logic [1:0]            out_tuser;         // merged[0], dropped_valid[1]

  fragment_pair_reassembly_table_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #CLK_HALF clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the pairing table.
  // rec_order[0] is the newest list position, rec_order[TABLE_SLOTS-1] the
  // oldest. Head flag and handle are only read for valid slots.
  // --------------------------------------------------------------------------
  logic                slot_used [TABLE_SLOTS];
  logic [SEQ_W-1:0]    slot_seq  [TABLE_SLOTS];
  logic                slot_head [TABLE_SLOTS];
  logic [HANDLE_W-1:0] slot_buf  [TABLE_SLOTS];
  logic [SLOT_W-1:0]   rec_order [TABLE_SLOTS];

  frag_t        pending_frags [$];   // fragments not yet transferred
  pair_result_t expected_pairs [$];  // predicted results, oldest first

  int errors      = 0;
  int frags_sent  = 0;
  int pairs_made  = 0;
  int evictions   = 0;
  int results_seen = 0;
  int cycle_count = 0;

  initial begin
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      slot_used[i] = 1'b0;
      slot_seq[i]  = '0;
      slot_head[i] = 1'b0;
      slot_buf[i]  = '0;
      rec_order[i] = SLOT_W'(i);
    end
  end

  // Search newest to oldest. An equal number or a same-flag partner pushes
  // that slot to the oldest end, so the insert below overwrites it. An
  // opposite-flag partner completes the pair and frees the slot.
  task automatic predict_pair(input frag_t f);
    pair_result_t      r;
    logic [SEQ_W-1:0]  partner;
    logic [HANDLE_W-1:0] hnd;
    logic [SLOT_W-1:0] s;
    logic              hit;
    logic              merge;
    int                hit_pos;
    r       = '0;
    hit     = 1'b0;
    merge   = 1'b0;
    hit_pos = 0;
    hnd     = f.handle & HANDLE_MASK;
    partner = f.is_head ? f.seqno + SEQ_W'(1) : f.seqno - SEQ_W'(1);
    for (int pos = 0; pos < TABLE_SLOTS && !hit; pos++) begin
      s = rec_order[pos];
      if (slot_used[s]) begin
        if (slot_seq[s] == f.seqno) begin
          hit = 1'b1;
          hit_pos = pos;
        end else if (slot_seq[s] == partner) begin
          hit = 1'b1;
          hit_pos = pos;
          merge = (slot_head[s] != f.is_head);
        end
      end
    end
    if (hit) begin
      s = rec_order[hit_pos];
      for (int i = hit_pos; i < TABLE_SLOTS - 1; i++)
        rec_order[i] = rec_order[i+1];
      rec_order[TABLE_SLOTS-1] = s;
    end
    if (merge) begin
      r.merged        = 1'b1;
      r.first_handle  = f.is_head ? hnd : slot_buf[s] & HANDLE_MASK;
      r.second_handle = f.is_head ? slot_buf[s] & HANDLE_MASK : hnd;
      slot_used[s]    = 1'b0;
      slot_seq[s]     = '0;
      pairs_made++;
    end else begin
      s = rec_order[TABLE_SLOTS-1];
      if (slot_used[s]) begin
        r.dropped_valid  = 1'b1;
        r.dropped_handle = slot_buf[s] & HANDLE_MASK;
        evictions++;
      end
      slot_used[s] = 1'b1;
      slot_seq[s]  = f.seqno;
      slot_head[s] = f.is_head;
      slot_buf[s]  = hnd;
      for (int i = TABLE_SLOTS - 1; i > 0; i--)
        rec_order[i] = rec_order[i-1];
      rec_order[0] = s;
    end
    expected_pairs.push_back(r);
  endtask

  // Idle length after a transfer: mostly short, a few long, with occasional
  // stretches of back-to-back transfers.
  task automatic next_gap(inout int quiet, output int gap);
    int r;
    r = $urandom_range(0, 99);
    if (quiet > 0) begin
      quiet--;
      gap = 0;
    end else if (r < 3) begin
      quiet = $urandom_range(20, 60);
      gap = 0;
    end else if (r < 40) begin
      gap = 0;
    end else if (r < 85) begin
      gap = $urandom_range(1, 3);
    end else if (r < 97) begin
      gap = $urandom_range(4, 12);
    end else begin
      gap = $urandom_range(20, 60);
    end
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  function automatic frag_t mk_frag(logic [SEQ_W-1:0] s, logic h, logic [HANDLE_W-1:0] b);
    frag_t f;
    f.seqno   = s;
    f.is_head = h;
    f.handle  = b;
    return f;
  endfunction

  // Biased toward the wrap point now and then.
  function automatic logic [SEQ_W-1:0] rand_seq();
    if ($urandom_range(0, 15) == 0)
      return SEQ_W'($urandom_range(0, 7) - 4);
    return SEQ_W'($urandom_range(0, 65535));
  endfunction

  // --------------------------------------------------------------------------
  // Driver: presents the head of pending_frags, holds it until the transfer,
  // predicts on the transfer edge, then idles for a random gap.
  // --------------------------------------------------------------------------
  int in_gap   = 0;
  int in_quiet = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_pair(pending_frags[0]);
        void'(pending_frags.pop_front());
        frags_sent++;
        next_gap(in_quiet, in_gap);
      end
      if (in_tvalid && !in_tready) begin
        // hold the item until it is taken
      end else if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_frags.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {pending_frags[0].handle, pending_frags[0].seqno};
        in_tuser  <= pending_frags[0].is_head;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compares each result transfer with the oldest prediction and
  // stalls the result channel at random.
  // --------------------------------------------------------------------------
  int out_stall = 0;
  int out_quiet = 0;

  always @(posedge clk) begin
    pair_result_t exp_r;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_pairs.size() == 0) begin
          $error("result transfer with nothing expected: tdata 0x%0h tuser 0x%0h",
                 out_tdata, out_tuser);
          errors++;
        end else begin
          exp_r = expected_pairs.pop_front();
          check_field("merged", int'(exp_r.merged), int'(out_tuser[0]));
          check_field("first_handle", int'(exp_r.first_handle), int'(out_tdata[7:0]));
          check_field("second_handle", int'(exp_r.second_handle), int'(out_tdata[15:8]));
          check_field("dropped_valid", int'(exp_r.dropped_valid), int'(out_tuser[1]));
          check_field("dropped_handle", int'(exp_r.dropped_handle),
                      int'(out_tdata[23:16]));
        end
        next_gap(out_quiet, out_stall);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: far above the slowest legal run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("fragment_pair_reassembly_table_top regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run.
  // --------------------------------------------------------------------------
  initial begin
    frag_t open_halves [$];  // buffered halves still waiting for a partner
    frag_t f;
    int    r;
    int    idx;
    int    made;
    int    drain;

    // Directed: merge both orders, 16-bit wrap, extremes of handle.
    pending_frags.push_back(mk_frag(16'h0000, 1'b1, 8'h00));
    pending_frags.push_back(mk_frag(16'h0001, 1'b0, 8'hFF));
    pending_frags.push_back(mk_frag(16'hFFFF, 1'b1, 8'h12));
    pending_frags.push_back(mk_frag(16'h0000, 1'b0, 8'h34));
    pending_frags.push_back(mk_frag(16'h8000, 1'b0, 8'hAA));
    pending_frags.push_back(mk_frag(16'h7FFF, 1'b1, 8'h55));
    // equal number already buffered, with either flag
    pending_frags.push_back(mk_frag(16'h1000, 1'b1, 8'h01));
    pending_frags.push_back(mk_frag(16'h1000, 1'b1, 8'h02));
    pending_frags.push_back(mk_frag(16'h1000, 1'b0, 8'h03));
    // partner number with the same flag: head-head, then tail-tail
    pending_frags.push_back(mk_frag(16'h2000, 1'b1, 8'h04));
    pending_frags.push_back(mk_frag(16'h1FFF, 1'b1, 8'h05));
    pending_frags.push_back(mk_frag(16'h3001, 1'b0, 8'h06));
    pending_frags.push_back(mk_frag(16'h3002, 1'b0, 8'h07));
    // fill the table past capacity so valid slots get evicted
    for (int k = 0; k < TABLE_SLOTS + 2; k++)
      pending_frags.push_back(mk_frag(16'h4000 + 16'(4 * k), k[0], 8'h80 + 8'(k)));

    // Random: mostly well-formed pairs, some duplicates, same-flag
    // partners and unrelated noise.
    made = 0;
    while (made < RANDOM_FRAGS) begin
      r = $urandom_range(0, 99);
      if (r < 45 || open_halves.size() == 0) begin
        f = mk_frag(rand_seq(), 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        open_halves.push_back(f);
        if (open_halves.size() > 12)
          void'(open_halves.pop_front());
      end else begin
        idx = (r < 60) ? 0 : $urandom_range(0, open_halves.size() - 1);
        f = open_halves[idx];
        if (r < 82) begin
          // matching partner, opposite flag
          f.seqno   = f.is_head ? f.seqno + 16'd1 : f.seqno - 16'd1;
          f.is_head = ~f.is_head;
          open_halves.delete(idx);
        end else if (r < 89) begin
          // same number again, any flag
          f.is_head = 1'($urandom_range(0, 1));
        end else if (r < 95) begin
          // partner number but the same flag
          f.seqno = f.is_head ? f.seqno + 16'd1 : f.seqno - 16'd1;
        end else begin
          f.seqno   = rand_seq();
          f.is_head = 1'($urandom_range(0, 1));
        end
        f.handle = 8'($urandom_range(0, 255));
      end
      pending_frags.push_back(f);
      made++;
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_frags.size() > 0 || in_tvalid || expected_pairs.size() > 0)
      @(posedge clk);
    for (drain = 0; drain < DRAIN_CYCLES; drain++)
      @(posedge clk);

    if (expected_pairs.size() > 0) begin
      $error("%0d expected results never arrived", expected_pairs.size());
      errors++;
    end

    $display("Covered %0d fragments: %0d pairs merged, %0d buffered halves evicted,",
             frags_sent, pairs_made, evictions);
    $display("%0d results checked, %0d errors, with random idling on both channels.",
             results_seen, errors);
    if (errors == 0) begin
      $display("fragment_pair_reassembly_table_top regression: pass");
    end else begin
      $display("fragment_pair_reassembly_table_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== fragment_pair_reassembly_table_top.f =====
sv/fprt_pkg.sv
sv/fprt_cmp.sv
sv/fprt_order.sv
sv/fragment_pair_reassembly_table_top.sv
verif/fragment_pair_reassembly_table_top_test.sv
